>>> hw/rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants of the sorted priority queue
// Field widths, operation codes and the structs that pass between cells.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int VAL_W  = 32;
  localparam int PRI_W  = 16;
  localparam int FILL_W = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [VAL_W-1:0] EMPTY_VALUE = '1;

  // Command broadcast to every cell for one accepted request.
  typedef struct packed {
    logic             ins;    // insert that fits
    logic             rem;    // remove from a non-empty queue
    logic             front;  // new entry goes ahead of the head entry
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
  } cmd_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic             valid;
    logic             at_or_after;  // insertion point is at or ahead of this cell
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
  } link_t;

  // Virtual neighbor ahead of the head cell: always occupied, never shifts.
  localparam link_t HEAD_LINK = '{valid: 1'b1, at_or_after: 1'b0, value: '0, prio: '0};
  // Virtual neighbor behind the tail cell: always empty.
  localparam link_t TAIL_LINK = '{valid: 1'b0, at_or_after: 1'b1, value: '0, prio: '0};

endpackage

>>> hw/rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell: one slot of the sorted priority queue
// Holds one entry; on each request it keeps it, takes the new entry, or takes
// the entry of the left or right neighbor.
// ----------------------------------------------------------------------------
module mpq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  mpq_pkg::cmd_t  cmd,
  input  mpq_pkg::link_t left,
  input  mpq_pkg::link_t right,
  output mpq_pkg::link_t self_o
);
  import mpq_pkg::*;

  logic             valid_r, valid_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [PRI_W-1:0] prio_r, prio_nxt;
  logic             at_or_after;

  // The queue is sorted, so the insertion point lies at or ahead of this
  // cell when the new entry goes to the front, this slot is free, or this
  // entry has a strictly larger priority number.
  assign at_or_after = cmd.front || !valid_r || (prio_r > cmd.prio);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (cmd.ins) begin
      valid_nxt = left.valid;
      if (left.at_or_after) begin
        value_nxt = left.value;
        prio_nxt  = left.prio;
      end else if (at_or_after) begin
        value_nxt = cmd.value;
        prio_nxt  = cmd.prio;
      end
    end else if (cmd.rem) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
      prio_nxt  = right.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign self_o = '{valid: valid_r, at_or_after: at_or_after, value: value_r, prio: prio_r};

endmodule

>>> hw/rtl/min_priority_queue.sv
// ----------------------------------------------------------------------------
// min_priority_queue: sorted priority queue of CAPACITY entries
// Requests arrive on the in_ stream: in_tuser selects insert or remove, and
// in_tdata carries the value and priority of an insert. Entries are kept in
// ascending priority order; a remove returns the entry at the front.
// Every accepted request yields exactly one result on the out_ stream, in
// the cycle after it is accepted. The block takes one request per cycle: all
// cells compare the broadcast priority and shift in the same cycle, so the
// rate is set by that single compare-and-select step in the cell row.
// A result waits in the output register while out_tready is low; a new
// request is still taken in the cycle that result leaves, so the stream
// keeps one request per cycle as long as the receiver keeps up. While the
// receiver stalls, in_tready drops and the queue holds its contents.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; entry storage is not cleared, only the per-cell valid bits.
// A remove from an empty queue returns -1 with was_empty set; an insert
// into a full queue is dropped with overflow set.
// ----------------------------------------------------------------------------
module min_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, lowest bit up: item_value[31:0], item_priority[47:32]
  input  logic [mpq_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: op (0 insert, 1 remove)
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata, lowest bit up: out_value[31:0], was_empty[32], overflow[33],
  // now_empty[34], fill_level[39:35]
  output logic [mpq_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import mpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Request fields.
  logic             acc;
  logic             op;
  logic [VAL_W-1:0] req_value;
  logic [PRI_W-1:0] req_prio;

  // Queue occupancy.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full, empty;

  // Cell row.
  cmd_t  cmd;
  link_t lk  [CAPACITY];
  link_t lft [CAPACITY];
  link_t rgt [CAPACITY];

  // Result register.
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [VAL_W-1:0]      res_value;
  logic [CNT_W+FILL_W-1:0] cnt_ext;

  assign in_tready = !out_tvalid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign op        = in_tuser;
  assign req_value = in_tdata[VAL_W-1:0];
  assign req_prio  = in_tdata[VAL_W+PRI_W-1:VAL_W];

  assign full  = (cnt_r == CNT_W'(CAPACITY));
  assign empty = (cnt_r == '0);

  // The head comparison decides whether a tie with the front entry goes in
  // front of it; it is broadcast so every cell sees the same decision.
  always_comb begin
    cmd.ins   = acc && (op == OP_INSERT) && !full;
    cmd.rem   = acc && (op == OP_REMOVE) && !empty;
    cmd.front = lk[0].valid && (req_prio <= lk[0].prio);
    cmd.value = req_value;
    cmd.prio  = req_prio;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lft[i] = HEAD_LINK;
    end else begin : g_mid
      assign lft[i] = lk[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rgt[i] = TAIL_LINK;
    end else begin : g_body
      assign rgt[i] = lk[i+1];
    end

    mpq_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .left   (lft[i]),
      .right  (rgt[i]),
      .self_o (lk[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.rem) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Fill level carries the low bits of the count only.
  assign cnt_ext = {{FILL_W{1'b0}}, cnt_nxt};

  always_comb begin
    res_value = '0;
    if (op == OP_REMOVE) begin
      res_value = empty ? EMPTY_VALUE : lk[0].value;
    end
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (acc) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {cnt_ext[FILL_W-1:0],
                        (cnt_nxt == '0),
                        (op == OP_INSERT) && full,
                        (op == OP_REMOVE) && empty,
                        res_value};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checking aids: occupied cells as a vector, and pairwise order.
  logic [CAPACITY-1:0] vld_vec;
  logic                order_ok;

  always_comb begin
    order_ok = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      vld_vec[i] = lk[i].valid;
      if (i > 0 && lk[i].valid && (lk[i-1].prio > lk[i].prio)) begin
        order_ok = 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // The counter agrees with the number of occupied cells.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(cnt_r))
    else $error("entry count disagrees with occupied cells");

  // Occupied cells always form a run starting at the head.
  a_packed_front: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_vec & (vld_vec + 1'b1)) == '0)
    else $error("occupied cells are not packed toward the head");

  // Occupied entries stay in ascending priority order.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n) order_ok)
    else $error("queue lost its priority order");

  // An insert into a full queue reports overflow in its result.
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == OP_INSERT) && full) |=> (out_tvalid && out_tdata[VAL_W+1]))
    else $error("insert into a full queue not flagged");
`endif

endmodule

>>> verif/min_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_tb: self-checking bench for the sorted priority queue
// A directed table covers the empty and full corners, equal priorities and
// extreme values, then random bursts of inserts and removes run under
// several sender and receiver idling mixes. Each accepted request is
// replayed on a local sorted-queue predictor and every result is compared
// field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module min_priority_queue_tb;
  import mpq_pkg::*;

  localparam int QCAP        = 16;
  localparam int DIR_ROWS    = 22;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  // Result layout, matching out_tdata from the highest bit down.
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              now_empty;
    logic              overflow;
    logic              was_empty;
    logic [VAL_W-1:0]  value;
  } qres_t;

  typedef struct {
    logic             op;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
    bit               typed;  // want holds a hand-written expectation
    qres_t            want;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // Predictor state: entries in service order, lowest priority first.
  logic [VAL_W-1:0] q_val  [QCAP];
  logic [PRI_W-1:0] q_prio [QCAP];
  int               q_count = 0;

  qres_t     due_results [$];
  stim_row_t dir_table [DIR_ROWS];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  bit        hold_go        = 1'b0;

  min_priority_queue #(.CAPACITY(QCAP)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the predictor and returns the result it yields.
  function automatic qres_t sorted_queue_step(logic op, logic [VAL_W-1:0] value,
                                              logic [PRI_W-1:0] prio);
    qres_t r;
    int    pos;
    r = '0;
    if (op == OP_INSERT) begin
      if (q_count >= QCAP) begin
        r.overflow = 1'b1;
      end else begin
        // A tie with the head goes in front; further back, ties go behind.
        pos = 0;
        if (q_count != 0 && prio > q_prio[0]) begin
          pos = 1;
          while (pos < q_count && q_prio[pos] <= prio) pos++;
        end
        for (int i = q_count; i > pos; i--) begin
          q_val[i]  = q_val[i-1];
          q_prio[i] = q_prio[i-1];
        end
        q_val[pos]  = value;
        q_prio[pos] = prio;
        q_count++;
      end
    end else begin
      if (q_count == 0) begin
        r.value     = EMPTY_VALUE;
        r.was_empty = 1'b1;
      end else begin
        r.value = q_val[0];
        for (int i = 1; i < q_count; i++) begin
          q_val[i-1]  = q_val[i];
          q_prio[i-1] = q_prio[i];
        end
        q_count--;
      end
    end
    r.now_empty = (q_count == 0);
    r.fill      = FILL_W'(q_count);
    return r;
  endfunction

  function automatic stim_row_t insert_row(logic [VAL_W-1:0] value, logic [PRI_W-1:0] prio);
    insert_row = '{op: OP_INSERT, value: value, prio: prio, typed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t remove_row();
    remove_row = '{op: OP_REMOVE, value: '0, prio: '0, typed: 1'b0, want: '0};
  endfunction

  // Offers one request, with random idle cycles ahead of it, and records the
  // expected result once the block has taken it.
  task automatic send_request(input logic op, input logic [VAL_W-1:0] value,
                              input logic [PRI_W-1:0] prio, input bit typed,
                              input qres_t want);
    qres_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      // Junk on the data lines while valid is low must be ignored.
      in_tvalid <= 1'b0;
      in_tdata  <= {16'($urandom), 32'($urandom)};
      in_tuser  <= 1'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {prio, value};
    do @(posedge clk); while (!in_tready);
    predicted = sorted_queue_step(op, value, prio);
    due_results.push_back(typed ? want : predicted);
  endtask

  // Random requests; insert_pct steers the queue toward full or empty.
  task automatic send_burst(input int count, input int insert_pct);
    logic             op;
    logic [PRI_W-1:0] prio;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      // Mostly a narrow range so that equal priorities are common.
      case ($urandom_range(9))
        0:          prio = '0;
        1:          prio = '1;
        2, 3, 4, 5: prio = PRI_W'($urandom_range(7));
        6, 7:       prio = PRI_W'($urandom_range(255));
        default:    prio = PRI_W'($urandom);
      endcase
      send_request(op, 32'($urandom), prio, 1'b0, '0);
    end
  endtask

  // Stops offering requests until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever hold_go toggles.
  always @(negedge clk) begin
    bit hold_seen;
    int hold_left;
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    qres_t got;
    qres_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = qres_t'(out_tdata);
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual %h",
                 $time, out_tdata);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        compare_field("out_value",  want.value,     got.value);
        compare_field("was_empty",  want.was_empty, got.was_empty);
        compare_field("overflow",   want.overflow,  got.overflow);
        compare_field("now_empty",  want.now_empty, got.now_empty);
        compare_field("fill_level", want.fill,      got.fill);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("min_priority_queue_tb: errors");
      $finish;
    end
  end

  initial begin
    int send_pcts [4];
    int recv_pcts [4];
    int bias;

    send_pcts = '{0, 77, 0, 7};
    recv_pcts = '{0, 0, 77, 7};

    // Directed table. Rows with typed set carry their result by hand.
    dir_table[0]  = '{op: OP_REMOVE, value: '0, prio: '0, typed: 1'b1,
                      want: '{fill: 5'd0, now_empty: 1'b1, overflow: 1'b0,
                              was_empty: 1'b1, value: EMPTY_VALUE}};
    dir_table[1]  = '{op: OP_INSERT, value: 32'h7FFF_FFFF, prio: 16'hFFFF, typed: 1'b1,
                      want: '{fill: 5'd1, now_empty: 1'b0, overflow: 1'b0,
                              was_empty: 1'b0, value: '0}};
    dir_table[2]  = '{op: OP_INSERT, value: 32'h8000_0000, prio: 16'h0000, typed: 1'b1,
                      want: '{fill: 5'd2, now_empty: 1'b0, overflow: 1'b0,
                              was_empty: 1'b0, value: '0}};
    // Tie with the head goes in front; tie with the tail goes behind it.
    dir_table[3]  = insert_row(32'h0000_0005, 16'h0000);
    dir_table[4]  = insert_row(32'h0000_0006, 16'hFFFF);
    dir_table[5]  = remove_row();
    // Fill to capacity with ties in the middle of the order.
    dir_table[6]  = insert_row(32'hFFFF_FFFF, 16'h8000);
    dir_table[7]  = insert_row(32'h0000_0000, 16'h0001);
    dir_table[8]  = insert_row(32'hA5A5_A5A5, 16'h7FFF);
    dir_table[9]  = insert_row(32'h5A5A_5A5A, 16'h8000);
    dir_table[10] = insert_row(32'h0000_0001, 16'hFFFE);
    dir_table[11] = insert_row(32'hFFFF_FFFE, 16'h0000);
    dir_table[12] = insert_row(32'h1234_5678, 16'h1234);
    dir_table[13] = insert_row(32'h8765_4321, 16'h1234);
    dir_table[14] = insert_row(32'h7FFF_FFFE, 16'hABCD);
    dir_table[15] = insert_row(32'h8000_0001, 16'h0002);
    dir_table[16] = insert_row(32'h0F0F_0F0F, 16'hFFFF);
    dir_table[17] = insert_row(32'hF0F0_F0F0, 16'h5555);
    dir_table[18] = insert_row(32'h3333_3333, 16'hAAAA);
    // The queue is full here, so this insert is dropped.
    dir_table[19] = '{op: OP_INSERT, value: 32'hC3C3_C3C3, prio: 16'h0000, typed: 1'b1,
                      want: '{fill: 5'd16, now_empty: 1'b0, overflow: 1'b1,
                              was_empty: 1'b0, value: '0}};
    dir_table[20] = remove_row();
    dir_table[21] = remove_row();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_request(dir_table[r].op, dir_table[r].value, dir_table[r].prio,
                   dir_table[r].typed, dir_table[r].want);
    end
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      for (int b = 0; b < 9; b++) begin
        // Long receiver hold-off while requests keep coming.
        if (phase == 0 && b == 1) hold_go = ~hold_go;
        case ($urandom_range(2))
          0:       bias = 85;
          1:       bias = 20;
          default: bias = 55;
        endcase
        send_burst($urandom_range(30, 55), bias);
        if (phase == 0 && b == 4) drain_results();
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("min_priority_queue_tb: clean");
    end else begin
      $display("min_priority_queue_tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_cell.sv
hw/rtl/min_priority_queue.sv
verif/min_priority_queue_tb.sv
